/* sv/euclidean_distance_isqrt_unit_assert.svh */
// assertion helpers shared by the distance unit modules
`ifndef EUCLIDEAN_DISTANCE_ISQRT_UNIT_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_ISQRT_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define EDIST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define EDIST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/edist_pkg.sv */
package edist_pkg;

    // fixed field widths of the stream items
    localparam int FIELD_W       = 15;
    localparam int NUM_COORDS    = 6;
    localparam int RES_W         = 16;
    localparam int S_TDATA_RAW_W = NUM_COORDS * FIELD_W;
    localparam int S_TDATA_W     = ((S_TDATA_RAW_W + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((RES_W + 7) / 8) * 8;
    localparam int S_TUSER_W     = 1;

    // defaults handed to the top level
    localparam int COORD_BITS_DEF = 15;
    localparam int QUEUE_DEPTH    = 4;

    // mode selector codes
    localparam logic FUNC_2D = 1'b0;
    localparam logic FUNC_3D = 1'b1;

endpackage

/* sv/edist_fifo.sv */
`include "euclidean_distance_isqrt_unit_assert.svh"

module edist_fifo import edist_pkg::*; #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    output logic              not_empty,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `EDIST_ASSERT_NOW(a_no_push_full, aclk, aresetn, push, !full, "push into full queue")
    `EDIST_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, pop, not_empty, "pop from empty queue")
    `EDIST_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

/* sv/edist_front.sv */
module edist_front import edist_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,
    input  logic [S_TUSER_W-1:0]    s_tuser,
    output logic                    push,
    output logic [2*COORD_BITS+1:0] push_data,
    input  logic                    queue_full
);

    localparam int CW    = COORD_BITS;
    localparam int SQ_W  = 2 * CW;
    localparam int SUM_W = 2 * CW + 2;

    logic [CW-1:0] ax, ay, az, bx, by_coord, bz;
    logic [CW-1:0] dx, dy, dz;

    // stage 1: per-axis absolute differences
    logic          v1_reg;
    logic [CW-1:0] dx_reg, dy_reg, dz_reg;
    // stage 2: squares
    logic            v2_reg;
    logic [SQ_W-1:0] sx_reg, sy_reg, sz_reg;
    // stage 3: sum of squares
    logic             v3_reg;
    logic [SUM_W-1:0] sum_reg;

    logic rdy1, rdy2, rdy3;

    assign ax       = s_tdata[0*FIELD_W +: CW];
    assign ay       = s_tdata[1*FIELD_W +: CW];
    assign az       = s_tdata[2*FIELD_W +: CW];
    assign bx       = s_tdata[3*FIELD_W +: CW];
    assign by_coord = s_tdata[4*FIELD_W +: CW];
    assign bz       = s_tdata[5*FIELD_W +: CW];

    assign dx = (ax >= bx) ? ax - bx : bx - ax;
    assign dy = (ay >= by_coord) ? ay - by_coord : by_coord - ay;
    // 2d mode drops the z axis by zeroing its difference
    assign dz = (s_tuser[0] == FUNC_3D) ? ((az >= bz) ? az - bz : bz - az) : '0;

    assign rdy3     = !v3_reg || !queue_full;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign push      = v3_reg && !queue_full;
    assign push_data = sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            dx_reg <= dx;
            dy_reg <= dy;
            dz_reg <= dz;
        end
        if (rdy2 && v1_reg) begin
            sx_reg <= dx_reg * dx_reg;
            sy_reg <= dy_reg * dy_reg;
            sz_reg <= dz_reg * dz_reg;
        end
        if (rdy3 && v2_reg) begin
            sum_reg <= SUM_W'(sx_reg) + SUM_W'(sy_reg) + SUM_W'(sz_reg);
        end
    end

endmodule

/* sv/edist_back.sv */
`include "euclidean_distance_isqrt_unit_assert.svh"

module edist_back import edist_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_not_empty,
    input  logic [2*COORD_BITS+1:0] q_data,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata
);

    localparam int RW    = COORD_BITS + 1;
    localparam int VAL_W = 2 * RW;
    localparam int REM_W = RW + 3;

    logic             vld_reg  [RW];
    logic [VAL_W-1:0] val_reg  [RW];
    logic [REM_W-1:0] rem_reg  [RW];
    logic [RW-1:0]    root_reg [RW];
    logic             rdy      [RW+1];

    assign rdy[RW] = m_tready;

    genvar i;
    generate
        for (i = 0; i < RW; i++) begin : g_stage
            logic             v_in;
            logic [VAL_W-1:0] val_in;
            logic [REM_W-1:0] rem_in;
            logic [RW-1:0]    root_in;
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;
            logic             ge;

            if (i == 0) begin : g_first
                assign v_in    = q_not_empty;
                assign val_in  = q_data;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_rest
                assign v_in    = vld_reg[i-1];
                assign val_in  = val_reg[i-1];
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
            end

            assign rdy[i] = !vld_reg[i] || rdy[i+1];

            // one bit pair of the radicand per stage
            assign rem_sh = {rem_in[REM_W-3:0], val_in[VAL_W-1 -: 2]};
            assign trial  = REM_W'({root_in, 2'b01});
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (rdy[i]) begin
                    vld_reg[i] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[i] && v_in) begin
                    val_reg[i]  <= val_in << 2;
                    rem_reg[i]  <= ge ? rem_sh - trial : rem_sh;
                    root_reg[i] <= {root_in[RW-2:0], ge};
                end
            end
        end
    endgenerate

    assign q_pop    = q_not_empty && rdy[0];
    assign m_tvalid = vld_reg[RW-1];
    assign m_tdata  = M_TDATA_W'(root_reg[RW-1]);

    `EDIST_ASSERT_NEXT(a_pop_fills, aclk, aresetn, q_pop, vld_reg[0],
        "popped item did not enter the root pipe")
    `EDIST_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(root_reg[RW-1]), "stalled result changed")

endmodule

/* sv/euclidean_distance_isqrt_unit.sv */
// euclidean distance unit: each input beat carries two points with unsigned
// coordinates and a 2d/3d selector; the result beat holds floor(sqrt(dx^2 +
// dy^2 [+ dz^2])), exact. only the low COORD_BITS bits of each coordinate are
// used, and az/bz play no part in 2d mode. throughput is one beat per clock
// in both directions while m_tready is held high; from input accept to result
// valid an item passes three front stages (differences, squares, sum), the
// queue register, and one square root stage per result bit, each stage
// settling one bit pair of the sum. the front and the root pipe are parted
// by a 4-entry queue, so s_tready does not follow m_tready in the same cycle.
// there is no state between items and no configuration; reset only clears
// the valid bits, the queue pointers and the queue count.
module euclidean_distance_isqrt_unit import edist_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // ax, ay, az, bx, by_coord, bz (15 bits each), zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,   // func: 0 = 2d, 1 = 3d
    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // dist_res (16 bits)
);

    localparam int SUM_W = 2 * COORD_BITS + 2;

    // sum of squares handed from the front to the queue
    logic             push;
    logic [SUM_W-1:0] push_data;
    logic             queue_full;

    // queue to root pipe
    logic             q_not_empty;
    logic             q_pop;
    logic [SUM_W-1:0] q_data;

    // front: differences, squares and their sum
    edist_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    // short queue so each side stalls on its own
    edist_fifo #(
        .DATA_W (SUM_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .pop_data  (q_data)
    );

    // back: pipelined bit-pair square root, last stage is the output register
    edist_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
